// ===== rtl/cael_pkg.sv =====
package cael_pkg;

    // Field widths fixed by the interface
    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int CAP_W     = 5;
    localparam int CNT_OUT_W = 5;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Word index of the capacity register (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Event kinds
    localparam logic FUNC_CLOSE = 1'b0;
    localparam logic FUNC_OPEN  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   request_id;
        logic [TIME_W-1:0] end_time;
    } t_item;

    typedef struct packed {
        logic                 evicted_valid;
        logic [ID_W-1:0]      evicted_id;
        logic [CNT_OUT_W-1:0] active_count;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic insert;
        logic scan;
        logic remove;
        logic result;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic over;
        logic scan_done;
    } t_sts;

endpackage

// ===== rtl/cael_ctrl.sv =====
module cael_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_func,
    input  cael_pkg::t_sts  i_sts,
    output cael_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INSERT = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_REMOVE = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_strobe, n_strobe;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_func == cael_pkg::FUNC_OPEN) ? S_INSERT : S_SCAN;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                if (i_sts.over) begin
                    n_state = S_SCAN;
                end else begin
                    o_cmd.result = 1'b1;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                o_cmd.remove = 1'b1;
                o_cmd.result = 1'b1;
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

// ===== rtl/cael_dp.sv =====
module cael_dp #(
    parameter int MAX_CAPACITY = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cael_pkg::t_cmd                   i_cmd,
    output cael_pkg::t_sts                   o_sts,
    input  cael_pkg::t_item                  i_item,
    input  logic [cael_pkg::CAP_W-1:0]       i_cap,
    output cael_pkg::t_result                o_result
);

    localparam int N      = MAX_CAPACITY + 1;
    localparam int IDX_W  = $clog2(N);
    localparam int CNT_W  = $clog2(N + 1);
    localparam int WIDE_W = (CNT_W > cael_pkg::CAP_W) ? CNT_W : cael_pkg::CAP_W;

    localparam logic [IDX_W-1:0]  LAST      = IDX_W'(N - 1);
    localparam logic [WIDE_W-1:0] MAX_CAP_W = WIDE_W'(MAX_CAPACITY);

    // Captured event
    logic                          r_func;
    logic [cael_pkg::ID_W-1:0]     r_req_id;
    logic [cael_pkg::TIME_W-1:0]   r_req_end;

    // Slot table: valid bits and ages in flops, id and end time in memory
    logic [N-1:0]                  r_valid;
    logic [IDX_W-1:0]              r_age [N];
    logic [cael_pkg::ID_W-1:0]     mem_id  [N];
    logic [cael_pkg::TIME_W-1:0]   mem_end [N];
    logic [CNT_W-1:0]              r_count;

    // Scan read pipe
    logic [IDX_W-1:0]              r_idx;
    logic                          r_pipe;
    logic [IDX_W-1:0]              r_q_slot;
    logic                          r_q_valid;
    logic [IDX_W-1:0]              r_q_age;
    logic [cael_pkg::ID_W-1:0]     r_q_id;
    logic [cael_pkg::TIME_W-1:0]   r_q_end;

    // Best candidate so far
    logic                          r_found;
    logic [IDX_W-1:0]              r_best_slot;
    logic [IDX_W-1:0]              r_best_age;
    logic [cael_pkg::TIME_W-1:0]   r_best_end;
    logic [cael_pkg::ID_W-1:0]     r_best_id;

    cael_pkg::t_result             r_res;

    logic                          has_free;
    logic [IDX_W-1:0]              free_idx;
    logic [CNT_W-1:0]              count_after;
    logic [CNT_W-1:0]              count_rm;
    logic [CNT_W-1:0]              res_cnt;
    logic [WIDE_W-1:0]             res_wide;
    logic [WIDE_W-1:0]             cap_w;
    logic [WIDE_W-1:0]             cap_eff;
    logic                          take;
    logic                          ev_valid;

    // Lowest free slot
    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                has_free = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // Clamp capacity into 1..MAX_CAPACITY
    always_comb begin
        cap_w   = WIDE_W'(i_cap);
        cap_eff = cap_w;
        if (cap_w == '0) begin
            cap_eff = WIDE_W'(1);
        end else if (cap_w > MAX_CAP_W) begin
            cap_eff = MAX_CAP_W;
        end
    end

    assign count_after = r_count + CNT_W'(has_free);
    assign count_rm    = r_found ? (r_count - CNT_W'(1)) : r_count;

    assign o_sts.over      = (WIDE_W'(count_after) > cap_eff);
    assign o_sts.scan_done = r_pipe && (r_q_slot == LAST);

    // Open: latest end, newest on tie. Close: first id match.
    always_comb begin
        take = 1'b0;
        if (i_cmd.scan && r_pipe && r_q_valid) begin
            if (r_func == cael_pkg::FUNC_OPEN) begin
                take = !r_found || (r_q_end > r_best_end) ||
                       ((r_q_end == r_best_end) && (r_q_age < r_best_age));
            end else begin
                take = !r_found && (r_q_id == r_req_id);
            end
        end
    end

    assign ev_valid = i_cmd.remove && r_found && (r_func == cael_pkg::FUNC_OPEN);
    assign res_cnt  = i_cmd.remove ? count_rm : count_after;
    assign res_wide = WIDE_W'(res_cnt);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_pipe  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pipe  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.insert && has_free) begin
                r_valid[free_idx] <= 1'b1;
                r_count           <= count_after;
            end
            if (i_cmd.scan) begin
                r_pipe <= 1'b1;
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.remove && r_found) begin
                r_valid[r_best_slot] <= 1'b0;
                r_count              <= count_rm;
            end
        end
    end

    // Ages: bump every live entry on insert, close the gap on remove
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N; i++) begin
            if (i_cmd.insert && has_free) begin
                if (r_valid[i]) begin
                    r_age[i] <= r_age[i] + IDX_W'(1);
                end
                if (IDX_W'(i) == free_idx) begin
                    r_age[i] <= '0;
                end
            end
            if (i_cmd.remove && r_found && r_valid[i] && (r_age[i] > r_best_age)) begin
                r_age[i] <= r_age[i] - IDX_W'(1);
            end
        end
    end

    // Id and end time store
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && has_free) begin
            mem_id[free_idx]  <= r_req_id;
            mem_end[free_idx] <= r_req_end;
        end
        if (i_cmd.scan) begin
            r_q_id  <= mem_id[r_idx];
            r_q_end <= mem_end[r_idx];
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_item.func;
            r_req_id  <= i_item.request_id;
            r_req_end <= i_item.end_time;
            r_idx     <= '0;
        end
        if (i_cmd.scan) begin
            r_q_valid <= r_valid[r_idx];
            r_q_age   <= r_age[r_idx];
            r_q_slot  <= r_idx;
            if (r_idx != LAST) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
        if (take) begin
            r_best_slot <= r_q_slot;
            r_best_age  <= r_q_age;
            r_best_end  <= r_q_end;
            r_best_id   <= r_q_id;
        end
        if (i_cmd.result) begin
            r_res.evicted_valid <= ev_valid;
            r_res.evicted_id    <= ev_valid ? r_best_id : '0;
            r_res.active_count  <= res_wide[cael_pkg::CNT_OUT_W-1:0];
        end
    end

    assign o_result = r_res;

endmodule

// ===== rtl/capacity_admission_evict_latest_end.sv =====
// Admission controller for time-sorted open/close events. Pulse start with an event while
// busy is low; the event is taken at that edge. Every event yields exactly one result,
// shown for a single cycle with o_result_valid high; the receiver cannot stall, so
// capture it then. Busy covers the insert on an open that needs no eviction, the slot
// scan and remove on a close, and insert, scan and remove on an open that evicts; the
// result appears in the cycle in which busy falls, and a new start may be given in that
// same cycle. The scan visits all N = MAX_CAPACITY + 1 slots, one slot a cycle, through
// the single read port of the id/end-time store and its read register. The user must
// write capacity through the APB port only while the block is idle; the block does not
// enforce it. 0 acts as 1 and values above MAX_CAPACITY act as MAX_CAPACITY.
module capacity_admission_evict_latest_end #(
    parameter int MAX_CAPACITY = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Event command channel
    input  logic                           start,
    output logic                           busy,
    input  cael_pkg::t_item                i_item,

    // Result channel
    output logic                           o_result_valid,
    output cael_pkg::t_result              o_result,

    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cael_pkg::APB_AW-1:0]    paddr,
    input  logic [cael_pkg::APB_DW-1:0]    pwdata,
    output logic [cael_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    logic [cael_pkg::CAP_W-1:0] r_cap;
    logic                       cfg_wr;
    logic                       reg_sel;
    cael_pkg::t_cmd             cmd;
    cael_pkg::t_sts             sts;

    // Capacity register: write on the access phase of a transfer
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == cael_pkg::REG_CAPACITY);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cael_pkg::CAP_RESET;
        end else if (cfg_wr && reg_sel) begin
            r_cap <= pwdata[cael_pkg::CAP_W-1:0];
        end
    end

    // Unmapped words read as zero
    assign prdata = reg_sel ? cael_pkg::APB_DW'(r_cap) : '0;

    // Sequencer: accept, insert, scan, remove, report
    cael_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_item.func),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_result_valid)
    );

    // Slot table, scan comparator and result register
    cael_dp #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_item   (i_item),
        .i_cap    (r_cap),
        .o_result (o_result)
    );

    // A result is only reported once the work on its event is finished
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    a_no_evict_zero_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.evicted_valid) |-> (o_result.evicted_id == '0))
        else $error("evicted id nonzero without eviction");

endmodule

// ===== tb/sv/capacity_admission_evict_latest_end_test.sv =====
`timescale 1ns / 1ps

module capacity_admission_evict_latest_end_test;

    localparam int MAX_CAP   = 16;
    localparam int NSLOTS    = MAX_CAP + 1;
    localparam int CLK_HALF  = 6;
    localparam int LIMIT     = 500000;
    localparam int SETTLE    = 30;
    localparam int PRINT_CAP = 40;

    // Byte address of the capacity register: word index sits at paddr[2]
    localparam logic [cael_pkg::APB_AW-1:0] CAP_ADDR = {cael_pkg::REG_CAPACITY, 2'b00};

    // Scoreboard: tracks the slot table the way the block should, queues the
    // result each accepted event should produce, and checks results in order.
    class admission_scoreboard;
        logic [cael_pkg::CAP_W-1:0]  cap_reg;
        bit                          live[NSLOTS];
        logic [cael_pkg::ID_W-1:0]   req_id[NSLOTS];
        logic [cael_pkg::TIME_W-1:0] end_at[NSLOTS];
        int                          rank[NSLOTS];  // entries inserted after this one, 0 = newest
        int                          live_count;
        cael_pkg::t_result           outcome_q[$];
        int                          errors;

        function new();
            cap_reg    = cael_pkg::CAP_RESET;
            live_count = 0;
            errors     = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_CAP) begin
                $display("error @%0t: %s", $time, what);
            end
            errors++;
        endtask

        function void set_capacity(logic [cael_pkg::CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        // Free a slot and close the gap it leaves in the insertion order.
        function void drop_slot(int s);
            int r;
            r = rank[s];
            live[s] = 1'b0;
            for (int i = 0; i < NSLOTS; i++) begin
                if (live[i] && rank[i] > r) rank[i]--;
            end
            if (live_count > 0) live_count--;
        endfunction

        // Apply one accepted event and queue the result it must produce.
        function void note_event(cael_pkg::t_item it);
            cael_pkg::t_result want;
            int                cap_eff;
            int                free_slot;
            int                victim;
            bit                found;

            want      = '0;
            cap_eff   = (cap_reg == 0) ? 1 : (cap_reg > MAX_CAP) ? MAX_CAP : int'(cap_reg);
            free_slot = -1;
            victim    = -1;
            found     = 1'b0;

            if (it.func == cael_pkg::FUNC_CLOSE) begin
                // Remove only the lowest-numbered match; absent ids change nothing
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!found && live[i] && req_id[i] == it.request_id) begin
                        drop_slot(i);
                        found = 1'b1;
                    end
                end
            end else begin
                for (int i = NSLOTS - 1; i >= 0; i--) begin
                    if (!live[i]) free_slot = i;
                end
                if (free_slot >= 0) begin
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (live[i]) rank[i]++;
                    end
                    live[free_slot]   = 1'b1;
                    req_id[free_slot] = it.request_id;
                    end_at[free_slot] = it.end_time;
                    rank[free_slot]   = 0;
                    live_count++;
                end
                if (live_count > cap_eff) begin
                    // Latest end wins; on a tie the newer entry goes
                    for (int i = 0; i < NSLOTS; i++) begin
                        if (live[i] && (victim < 0 || end_at[i] > end_at[victim] ||
                                (end_at[i] == end_at[victim] && rank[i] < rank[victim]))) begin
                            victim = i;
                        end
                    end
                    if (victim >= 0) begin
                        want.evicted_valid = 1'b1;
                        want.evicted_id    = req_id[victim];
                        drop_slot(victim);
                    end
                end
            end
            want.active_count = cael_pkg::CNT_OUT_W'(live_count);
            outcome_q = {outcome_q, want};
        endfunction

        task check_result(cael_pkg::t_result got);
            cael_pkg::t_result want;
            if (outcome_q.size() == 0) begin
                report_mismatch("result with no event pending");
                return;
            end
            want = outcome_q.pop_front();
            if (got.evicted_valid !== want.evicted_valid) begin
                report_mismatch($sformatf("evicted_valid %b, want %b",
                    got.evicted_valid, want.evicted_valid));
            end
            if (got.evicted_id !== want.evicted_id) begin
                report_mismatch($sformatf("evicted_id %h, want %h",
                    got.evicted_id, want.evicted_id));
            end
            if (got.active_count !== want.active_count) begin
                report_mismatch($sformatf("active_count %0d, want %0d",
                    got.active_count, want.active_count));
            end
        endtask

        // Pick the id of some active entry so closes mostly hit.
        function bit pick_live(output logic [cael_pkg::ID_W-1:0] id);
            int idx[$];
            id = '0;
            foreach (live[i]) begin
                if (live[i]) idx = {idx, i};
            end
            if (idx.size() == 0) return 1'b0;
            id = req_id[idx[$urandom_range(idx.size() - 1)]];
            return 1'b1;
        endfunction
    endclass

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start   = 1'b0;
    logic                        busy;
    cael_pkg::t_item             i_item  = '0;
    logic                        o_result_valid;
    cael_pkg::t_result           o_result;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [cael_pkg::APB_AW-1:0] paddr   = '0;
    logic [cael_pkg::APB_DW-1:0] pwdata  = '0;
    logic [cael_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    admission_scoreboard sb;
    int                  cycle_count = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    capacity_admission_evict_latest_end #(
        .MAX_CAPACITY(MAX_CAP)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Results cannot be held off: take every strobe at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_result);
    end

    // Watchdog: end the run if the block stops answering.
    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("capacity_admission_evict_latest_end: mismatch");
        $finish;
    end

    // End times: bias toward a small range so ties on the latest end are common,
    // keep the extremes, and let the rest span the full field.
    function automatic logic [cael_pkg::TIME_W-1:0] pick_end();
        case ($urandom_range(9))
            0:             return '0;
            1:             return '1;
            2, 3, 4, 5:    return cael_pkg::TIME_W'($urandom_range(15));
            default:       return cael_pkg::TIME_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed traffic: opens, half from a small id pool (duplicates happen),
    // closes of live ids, plus closes of random ids that miss.
    function automatic cael_pkg::t_item next_random_event();
        cael_pkg::t_item           it;
        int                        roll;
        logic [cael_pkg::ID_W-1:0] lid;
        bit                        has;
        roll        = $urandom_range(99);
        it.end_time = pick_end();
        if (roll < 58) begin
            it.func       = cael_pkg::FUNC_OPEN;
            it.request_id = $urandom_range(1) ? cael_pkg::ID_W'($urandom_range(31))
                                              : cael_pkg::ID_W'($urandom);
        end else begin
            it.func = cael_pkg::FUNC_CLOSE;
            has     = sb.pick_live(lid);
            it.request_id = (has && roll < 92) ? lid : cael_pkg::ID_W'($urandom);
        end
        return it;
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int next_gap(bit gapless);
        int r;
        if (gapless) return 0;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Present an event and hold it until the transfer happens (busy low at the edge).
    task automatic send_event(cael_pkg::t_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_event(it);
        @(negedge i_clk);
    endtask

    // Drop start for the given gap and put junk on the item bus meanwhile.
    task automatic pause(int n);
        if (n > 0) begin
            start  <= 1'b0;
            i_item <= next_random_event();
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic put(logic f, logic [cael_pkg::ID_W-1:0] id,
                       logic [cael_pkg::TIME_W-1:0] e);
        cael_pkg::t_item it;
        it.func       = f;
        it.request_id = id;
        it.end_time   = e;
        send_event(it);
        pause(next_gap(1'b0));
    endtask

    // Wait until every queued result has come back, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write of the capacity register with junk in the unused upper bits,
    // followed by a read back of the stored field.
    task automatic write_capacity(logic [cael_pkg::CAP_W-1:0] c);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {(cael_pkg::APB_DW - cael_pkg::CAP_W)'($urandom), c};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_capacity(c);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[cael_pkg::CAP_W-1:0] !== c) begin
            sb.report_mismatch($sformatf("capacity read %0d, want %0d",
                prdata[cael_pkg::CAP_W-1:0], c));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [cael_pkg::CAP_W-1:0] caps[8];
        bit                         gapless;

        caps = '{5'd31, 5'd1, 5'd17, 5'd5, 5'd16, 5'd0, 5'd2, 5'd12};
        sb   = new();

        // Hold reset, then release it on a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset capacity: id and end extremes, a miss, duplicate ids
        put(cael_pkg::FUNC_OPEN,  16'h0000, 32'h0000_0000);
        put(cael_pkg::FUNC_OPEN,  16'hFFFF, 32'hFFFF_FFFF);
        put(cael_pkg::FUNC_CLOSE, 16'h1234, 32'hFFFF_FFFF);
        put(cael_pkg::FUNC_CLOSE, 16'hFFFF, 32'h0000_0000);
        put(cael_pkg::FUNC_OPEN,  16'h0000, 32'h0000_0007);
        put(cael_pkg::FUNC_CLOSE, 16'h0000, 32'h0000_0000);
        put(cael_pkg::FUNC_CLOSE, 16'h0000, 32'h5555_AAAA);
        put(cael_pkg::FUNC_CLOSE, 16'h0000, 32'h0000_0000);
        drain();

        // Capacity two: tie evicts the entry just inserted, latest end goes
        // even when newest, newer of a tie goes
        write_capacity(5'd2);
        put(cael_pkg::FUNC_OPEN,  16'd1, 32'd5);
        put(cael_pkg::FUNC_OPEN,  16'd2, 32'd5);
        put(cael_pkg::FUNC_OPEN,  16'd3, 32'd5);
        put(cael_pkg::FUNC_OPEN,  16'd4, 32'd9);
        put(cael_pkg::FUNC_OPEN,  16'd5, 32'd1);
        put(cael_pkg::FUNC_CLOSE, 16'd1, 32'd0);
        put(cael_pkg::FUNC_CLOSE, 16'd5, 32'd0);
        drain();

        // Zero capacity behaves as one
        write_capacity(5'd0);
        put(cael_pkg::FUNC_OPEN,  16'd6, 32'd3);
        put(cael_pkg::FUNC_OPEN,  16'd7, 32'd3);
        put(cael_pkg::FUNC_OPEN,  16'd8, 32'd0);
        put(cael_pkg::FUNC_CLOSE, 16'd8, 32'd0);
        drain();

        // Lower capacity under load: one eviction per open, count stays high
        write_capacity(5'd16);
        put(cael_pkg::FUNC_OPEN,  16'd10, 32'd40);
        put(cael_pkg::FUNC_OPEN,  16'd11, 32'd30);
        put(cael_pkg::FUNC_OPEN,  16'd12, 32'd20);
        put(cael_pkg::FUNC_OPEN,  16'd13, 32'd10);
        drain();
        write_capacity(5'd1);
        put(cael_pkg::FUNC_OPEN,  16'd14, 32'd25);
        drain();

        // Random phases, each at its own capacity; active entries carry over
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            gapless = (p % 3 == 1);
            repeat (115) begin
                send_event(next_random_event());
                pause(next_gap(gapless));
            end
            drain();
        end

        start <= 1'b0;
        while (sb.outcome_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (sb.outcome_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.outcome_q.size()));
        end

        if (sb.errors == 0) begin
            $display("capacity_admission_evict_latest_end: match");
        end else begin
            $display("capacity_admission_evict_latest_end: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cael_pkg.sv
rtl/cael_ctrl.sv
rtl/cael_dp.sv
rtl/capacity_admission_evict_latest_end.sv
tb/sv/capacity_admission_evict_latest_end_test.sv
